// ===== src/lzwc_pkg.sv =====
`default_nettype none

package lzwc_pkg;

    // Default build: 12-bit codes, 4096-entry dictionary, 16 search cells
    localparam int CODE_LIMIT_DEF = 4096;
    localparam int CODE_BITS_DEF  = 12;
    localparam int NUM_CELLS_DEF  = 16;

    localparam int BYTE_W     = 8;
    // Codes below this are the implicit single-byte strings
    localparam int FIRST_FREE = 256;

    // Control part of a probe that travels down the cell chain
    typedef struct packed {
        logic active;   // probe slot carries a row lookup
        logic last;     // final row of the current search
        logic hit;      // some cell upstream matched the key
    } t_probe_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SEARCH,
        S_DRAIN,
        S_MISS,
        S_FINISH,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

// ===== src/lzwc_cell.sv =====
`default_nettype none

// One search cell: owns a bank of dictionary slots (code = {row, cell index}),
// compares its stored key against the passing probe and forwards the probe.
module lzwc_cell #(
    parameter int KEY_W      = lzwc_pkg::CODE_BITS_DEF + lzwc_pkg::BYTE_W,
    parameter int ROW_W      = 8,
    parameter int CELL_W     = 4,
    parameter int SLOT_W     = 12,
    parameter int CNT_W      = 13,
    parameter int BANK_DEPTH = 256,
    parameter int CELL_IDX   = 0
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire lzwc_pkg::t_probe_ctl  i_ctl,
    input  wire [ROW_W-1:0]            i_row,
    input  wire [KEY_W-1:0]            i_key,
    input  wire [SLOT_W-1:0]           i_hit_slot,
    input  wire [CNT_W-1:0]            i_count,
    input  wire                        i_wr_en,
    input  wire [ROW_W-1:0]            i_wr_row,
    input  wire [KEY_W-1:0]            i_wr_key,
    output lzwc_pkg::t_probe_ctl       o_ctl,
    output logic [ROW_W-1:0]           o_row,
    output logic [KEY_W-1:0]           o_key,
    output logic [SLOT_W-1:0]          o_hit_slot
);

    logic [KEY_W-1:0]     r_mem [BANK_DEPTH];
    logic [KEY_W-1:0]     r_rdata;
    lzwc_pkg::t_probe_ctl r_ctl;
    logic [ROW_W-1:0]     r_row;
    logic [KEY_W-1:0]     r_key;
    logic [SLOT_W-1:0]    r_hit_slot;

    logic [SLOT_W-1:0]    w_slot;
    logic                 w_in_range;
    logic                 w_own_hit;

    // bank: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_row] <= i_wr_key;
        end
        r_rdata <= r_mem[i_row];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row      <= i_row;
        r_key      <= i_key;
        r_hit_slot <= i_hit_slot;
    end

    // only slots below the fill count hold live entries
    assign w_slot     = {r_row, CELL_W'(CELL_IDX)};
    assign w_in_range = ({1'b0, w_slot} < i_count);
    assign w_own_hit  = r_ctl.active && w_in_range && (r_rdata == r_key);

    always_comb begin
        o_ctl      = r_ctl;
        o_ctl.hit  = r_ctl.hit | w_own_hit;
        o_row      = r_row;
        o_key      = r_key;
        o_hit_slot = w_own_hit ? w_slot : r_hit_slot;
    end

endmodule

`default_nettype wire

// ===== src/lzwc_out_fifo.sv =====
`default_nettype none

// Two-entry result queue; head entry drives the output port.
module lzwc_out_fifo #(
    parameter int DATA_W = lzwc_pkg::CODE_BITS_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  wire [DATA_W-1:0]  i_push_code,
    input  wire               i_push_eos,
    output logic              o_push_ready,
    output logic              o_valid,
    input  wire               i_ready,
    output logic [DATA_W-1:0] o_code,
    output logic              o_eos
);

    logic              r_vld0, r_vld1;
    logic [DATA_W-1:0] r_code0, r_code1;
    logic              r_eos0, r_eos1;
    logic              n_vld0, n_vld1;
    logic [DATA_W-1:0] n_code0, n_code1;
    logic              n_eos0, n_eos1;

    assign o_push_ready = !r_vld1;
    assign o_valid      = r_vld0;
    assign o_code       = r_code0;
    assign o_eos        = r_eos0;

    always_comb begin
        n_vld0  = r_vld0;
        n_vld1  = r_vld1;
        n_code0 = r_code0;
        n_code1 = r_code1;
        n_eos0  = r_eos0;
        n_eos1  = r_eos1;
        if (r_vld0 && i_ready) begin
            n_vld0  = r_vld1;
            n_code0 = r_code1;
            n_eos0  = r_eos1;
            n_vld1  = 1'b0;
        end
        if (i_push && !r_vld1) begin
            if (!n_vld0) begin
                n_vld0  = 1'b1;
                n_code0 = i_push_code;
                n_eos0  = i_push_eos;
            end else begin
                n_vld1  = 1'b1;
                n_code1 = i_push_code;
                n_eos1  = i_push_eos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
            r_vld1 <= 1'b0;
        end else begin
            r_vld0 <= n_vld0;
            r_vld1 <= n_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code0 <= n_code0;
        r_code1 <= n_code1;
        r_eos0  <= n_eos0;
        r_eos1  <= n_eos1;
    end

endmodule

`default_nettype wire

// ===== src/lzw_byte_compressor.sv =====
`default_nettype none

// LZW byte compressor. One byte per input transaction (with a flag on the
// last byte of a stream); output transactions carry CODE_BITS-bit codes, the
// last one of a stream tagged end_of_stream. Learned strings take codes 256
// and up; when all CODE_LIMIT codes are used the dictionary restarts at 256
// before the next byte, and every stream starts with a fresh dictionary.
// The dictionary lives in a row of NUM_CELLS search cells; cell c holds codes
// c, c+NUM_CELLS, ... in its own bank. A lookup pushes one probe per bank
// row that holds learned codes into the chain, one row per cycle, and the
// probe picks up the match as it passes the cells. No lookup is needed on
// the first byte of a stream or while no codes are learned yet. Lookup time
// grows with the row sweep and the chain length; a full output queue stalls
// the block on top. A byte may be taken while up to two earlier results
// still sit in the output queue. No clearing pass: entries at or above the
// fill count are never matched. NUM_CELLS must be a power of two between 2
// and 256.
module lzw_byte_compressor #(
    parameter int CODE_LIMIT = lzwc_pkg::CODE_LIMIT_DEF,
    parameter int CODE_BITS  = lzwc_pkg::CODE_BITS_DEF,
    parameter int NUM_CELLS  = lzwc_pkg::NUM_CELLS_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    // input transaction
    input  wire                     i_valid,
    output logic                    o_ready,
    input  wire [7:0]               i_in_byte,
    input  wire                     i_final_byte,
    // output transaction
    output logic                    o_valid,
    input  wire                     i_ready,
    output logic [CODE_BITS-1:0]    o_out_code,
    output logic                    o_end_of_stream
);

    localparam int KEY_W      = CODE_BITS + lzwc_pkg::BYTE_W;
    localparam int CELL_W     = $clog2(NUM_CELLS);
    localparam int BANK_DEPTH = (CODE_LIMIT + NUM_CELLS - 1) / NUM_CELLS;
    localparam int ROW_W      = $clog2(BANK_DEPTH);
    localparam int SLOT_W     = ROW_W + CELL_W;
    localparam int CNT_W      = SLOT_W + 1;
    localparam int FIRST_ROW  = lzwc_pkg::FIRST_FREE / NUM_CELLS;

    // controller registers
    lzwc_pkg::t_state    r_state, n_state;
    logic [7:0]          r_byte, n_byte;
    logic                r_last, n_last;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CODE_BITS-1:0] r_match_code, n_match_code;
    logic                r_match_valid, n_match_valid;
    logic [ROW_W-1:0]    r_row, n_row;
    logic [ROW_W-1:0]    r_end_row, n_end_row;
    logic                r_hit, n_hit;
    logic [SLOT_W-1:0]   r_hit_slot, n_hit_slot;
    logic [CODE_BITS-1:0] r_res0_code, n_res0_code;
    logic [CODE_BITS-1:0] r_res1_code, n_res1_code;
    logic [1:0]          r_res_vld, n_res_vld;

    // cell chain
    lzwc_pkg::t_probe_ctl w_ctl      [NUM_CELLS+1];
    logic [ROW_W-1:0]     w_row      [NUM_CELLS+1];
    logic [KEY_W-1:0]     w_key      [NUM_CELLS+1];
    logic [SLOT_W-1:0]    w_slot     [NUM_CELLS+1];

    logic [KEY_W-1:0]     w_probe_key;
    logic [CNT_W-1:0]     w_count_m1;
    logic                 w_accept;
    logic                 w_wr_en;
    logic                 w_tail_active;
    logic                 w_tail_last;
    logic                 w_hit_now;
    logic [SLOT_W-1:0]    w_hit_slot_now;

    // output queue
    logic                 w_push;
    logic [CODE_BITS-1:0] w_push_code;
    logic                 w_push_eos;
    logic                 w_push_ready;

    assign o_ready     = (r_state == lzwc_pkg::S_IDLE);
    assign w_accept    = i_valid && o_ready;
    assign w_probe_key = {r_match_code, r_byte};
    assign w_count_m1  = r_count - CNT_W'(1);
    assign w_wr_en     = (r_state == lzwc_pkg::S_MISS);

    // probe leaving the last cell
    assign w_tail_active  = w_ctl[NUM_CELLS].active;
    assign w_tail_last    = w_tail_active && w_ctl[NUM_CELLS].last;
    assign w_hit_now      = r_hit || (w_tail_active && w_ctl[NUM_CELLS].hit);
    assign w_hit_slot_now = (w_tail_active && w_ctl[NUM_CELLS].hit) ?
                            w_slot[NUM_CELLS] : r_hit_slot;

    // chain head: one probe per row while searching
    assign w_ctl[0]  = '{active: (r_state == lzwc_pkg::S_SEARCH),
                         last:   (r_row == r_end_row),
                         hit:    1'b0};
    assign w_row[0]  = r_row;
    assign w_key[0]  = w_probe_key;
    assign w_slot[0] = '0;

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        logic w_sel;
        assign w_sel = w_wr_en && (r_count[CELL_W-1:0] == CELL_W'(g));

        lzwc_cell #(
            .KEY_W      (KEY_W),
            .ROW_W      (ROW_W),
            .CELL_W     (CELL_W),
            .SLOT_W     (SLOT_W),
            .CNT_W      (CNT_W),
            .BANK_DEPTH (BANK_DEPTH),
            .CELL_IDX   (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl[g]),
            .i_row      (w_row[g]),
            .i_key      (w_key[g]),
            .i_hit_slot (w_slot[g]),
            .i_count    (r_count),
            .i_wr_en    (w_sel),
            .i_wr_row   (r_count[SLOT_W-1:CELL_W]),
            .i_wr_key   (w_probe_key),
            .o_ctl      (w_ctl[g+1]),
            .o_row      (w_row[g+1]),
            .o_key      (w_key[g+1]),
            .o_hit_slot (w_slot[g+1])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lzwc_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = lzwc_pkg::S_DECIDE;
                end
            end
            lzwc_pkg::S_DECIDE: begin
                if (!r_match_valid) begin
                    n_state = lzwc_pkg::S_FINISH;
                end else if (r_count == CNT_W'(lzwc_pkg::FIRST_FREE)) begin
                    n_state = lzwc_pkg::S_MISS;
                end else begin
                    n_state = lzwc_pkg::S_SEARCH;
                end
            end
            lzwc_pkg::S_SEARCH: begin
                if (r_row == r_end_row) begin
                    n_state = lzwc_pkg::S_DRAIN;
                end
            end
            lzwc_pkg::S_DRAIN: begin
                if (w_tail_last) begin
                    n_state = w_hit_now ? lzwc_pkg::S_FINISH : lzwc_pkg::S_MISS;
                end
            end
            lzwc_pkg::S_MISS: begin
                n_state = lzwc_pkg::S_FINISH;
            end
            lzwc_pkg::S_FINISH: begin
                if (r_last || (r_res_vld != 2'b00)) begin
                    n_state = lzwc_pkg::S_EMIT;
                end else begin
                    n_state = lzwc_pkg::S_IDLE;
                end
            end
            lzwc_pkg::S_EMIT: begin
                if (w_push_ready && (r_res_vld != 2'b11)) begin
                    n_state = lzwc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lzwc_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_byte        = r_byte;
        n_last        = r_last;
        n_count       = r_count;
        n_match_code  = r_match_code;
        n_match_valid = r_match_valid;
        n_row         = r_row;
        n_end_row     = r_end_row;
        n_hit         = r_hit;
        n_hit_slot    = r_hit_slot;
        n_res0_code   = r_res0_code;
        n_res1_code   = r_res1_code;
        n_res_vld     = r_res_vld;
        w_push        = 1'b0;
        w_push_code   = r_res0_code;
        w_push_eos    = 1'b0;
        case (r_state)
            lzwc_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_byte    = i_in_byte;
                    n_last    = i_final_byte;
                    n_res_vld = 2'b00;
                    // dictionary full: restart learned codes
                    if (r_count >= CNT_W'(CODE_LIMIT)) begin
                        n_count = CNT_W'(lzwc_pkg::FIRST_FREE);
                    end
                end
            end
            lzwc_pkg::S_DECIDE: begin
                if (!r_match_valid) begin
                    n_match_code  = CODE_BITS'(r_byte);
                    n_match_valid = 1'b1;
                end
                n_row     = ROW_W'(FIRST_ROW);
                n_end_row = w_count_m1[SLOT_W-1:CELL_W];
                n_hit     = 1'b0;
            end
            lzwc_pkg::S_SEARCH: begin
                n_row = r_row + ROW_W'(1);
                if (w_tail_active && w_ctl[NUM_CELLS].hit) begin
                    n_hit      = 1'b1;
                    n_hit_slot = w_slot[NUM_CELLS];
                end
            end
            lzwc_pkg::S_DRAIN: begin
                if (w_tail_active && w_ctl[NUM_CELLS].hit) begin
                    n_hit      = 1'b1;
                    n_hit_slot = w_slot[NUM_CELLS];
                end
                if (w_tail_last && w_hit_now) begin
                    n_match_code = CODE_BITS'(w_hit_slot_now);
                end
            end
            lzwc_pkg::S_MISS: begin
                // cells store the new string this cycle
                n_count      = r_count + CNT_W'(1);
                n_res0_code  = r_match_code;
                n_res_vld[0] = 1'b1;
                n_match_code = CODE_BITS'(r_byte);
            end
            lzwc_pkg::S_FINISH: begin
                if (r_last) begin
                    n_res1_code   = r_match_code;
                    n_res_vld[1]  = 1'b1;
                    n_match_code  = '0;
                    n_match_valid = 1'b0;
                    n_count       = CNT_W'(lzwc_pkg::FIRST_FREE);
                end
            end
            lzwc_pkg::S_EMIT: begin
                w_push = 1'b1;
                if (r_res_vld[0]) begin
                    w_push_code = r_res0_code;
                    w_push_eos  = 1'b0;
                    if (w_push_ready) begin
                        n_res_vld[0] = 1'b0;
                    end
                end else begin
                    w_push_code = r_res1_code;
                    w_push_eos  = 1'b1;
                    if (w_push_ready) begin
                        n_res_vld[1] = 1'b0;
                    end
                end
            end
            default: begin
                n_res_vld = 2'b00;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= lzwc_pkg::S_IDLE;
            r_count       <= CNT_W'(lzwc_pkg::FIRST_FREE);
            r_match_code  <= '0;
            r_match_valid <= 1'b0;
            r_hit         <= 1'b0;
            r_res_vld     <= 2'b00;
        end else begin
            r_state       <= n_state;
            r_count       <= n_count;
            r_match_code  <= n_match_code;
            r_match_valid <= n_match_valid;
            r_hit         <= n_hit;
            r_res_vld     <= n_res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte      <= n_byte;
        r_last      <= n_last;
        r_row       <= n_row;
        r_end_row   <= n_end_row;
        r_hit_slot  <= n_hit_slot;
        r_res0_code <= n_res0_code;
        r_res1_code <= n_res1_code;
    end

    lzwc_out_fifo #(
        .DATA_W (CODE_BITS)
    ) u_out_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_push_code  (w_push_code),
        .i_push_eos   (w_push_eos),
        .o_push_ready (w_push_ready),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_code       (o_out_code),
        .o_eos        (o_end_of_stream)
    );

    // fill count stays within the learned-code range
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(lzwc_pkg::FIRST_FREE)) && (r_count <= CNT_W'(CODE_LIMIT)))
        else $error("entry count out of range");

    // a new string is only stored below the code limit
    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lzwc_pkg::S_MISS) |-> (r_count < CNT_W'(CODE_LIMIT)))
        else $error("dictionary insert past code limit");

    // probes leave the chain only while a lookup is running
    a_probe_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tail_active |-> ((r_state == lzwc_pkg::S_SEARCH) ||
                           (r_state == lzwc_pkg::S_DRAIN)))
        else $error("stray probe at chain tail");

    // a new byte is only taken once the previous results are queued
    a_results_flushed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> (r_res_vld == 2'b00))
        else $error("byte accepted with results pending");

endmodule

`default_nettype wire

// ===== tb/sv/lzw_byte_compressor_test.sv =====
`timescale 1ns / 100ps

// One expected output transaction: a code and its end-of-stream tag
typedef struct packed {
    logic [lzwc_pkg::CODE_BITS_DEF-1:0] code;
    logic                               eos;
} t_code_item;

// Scoreboard: keeps its own LZW dictionary and match state, turns every
// accepted byte into the codes it must produce, and checks the codes that
// come out against them in order.
class code_board;
    localparam int CW = lzwc_pkg::CODE_BITS_DEF;
    int unsigned errors;
    int unsigned checked;
    int unsigned fill;       // number of defined codes
    bit [CW-1:0] cur_match;
    bit match_on;
    // learned strings: {prefix code, byte} -> code
    int unsigned learned[bit [CW+7:0]];
    t_code_item pending[$];

    function new();
        errors    = 0;
        checked   = 0;
        cur_match = '0;
        match_on  = 1'b0;
        restart_dict();
    endfunction

    // Entries at or above the fill count are dead, so a restart forgets them all
    function void restart_dict();
        fill = lzwc_pkg::FIRST_FREE;
        learned.delete();
    endfunction

    function void emit(bit [CW-1:0] code, bit eos);
        t_code_item c;
        c.code = code;
        c.eos  = eos;
        pending.insert(pending.size(), c);
    endfunction

    // Input transaction accepted: advance the dictionary, queue its codes
    function void note_byte(bit [7:0] b, bit fin);
        bit [CW+7:0] key;
        if (fill >= lzwc_pkg::CODE_LIMIT_DEF) begin
            restart_dict();
        end
        key = {cur_match, b};
        if (!match_on) begin
            cur_match = CW'(b);
            match_on  = 1'b1;
        end else if (learned.exists(key)) begin
            cur_match = CW'(learned[key]);
        end else begin
            learned[key] = fill;
            fill++;
            emit(cur_match, 1'b0);
            cur_match = CW'(b);
        end
        if (fin) begin
            emit(cur_match, 1'b1);
            cur_match = '0;
            match_on  = 1'b0;
            restart_dict();
        end
    endfunction

    // Printing stops after a couple hundred lines; counting does not
    task report(string what);
        if (errors < 200)
            $display("MISMATCH %s", what);
        errors++;
    endtask

    // Output transaction accepted: compare with the oldest expected code
    task check_code(logic [CW-1:0] code, logic eos);
        t_code_item want;
        checked++;
        if (pending.size() == 0) begin
            report($sformatf("result %0d: code %0d eos %0b, nothing expected",
                             checked, code, eos));
            return;
        end
        want = pending.pop_front();
        if (code !== want.code)
            report($sformatf("result %0d: code %0d, expected %0d",
                             checked, code, want.code));
        if (eos !== want.eos)
            report($sformatf("result %0d: end_of_stream %0b, expected %0b",
                             checked, eos, want.eos));
    endtask

    task close_out();
        t_code_item want;
        while (pending.size() != 0) begin
            want = pending.pop_front();
            report($sformatf("code %0d eos %0b never came out", want.code, want.eos));
        end
    endtask
endclass

module lzw_byte_compressor_test;

    localparam int          HALF_PERIOD  = 10;
    localparam int          CODE_W       = lzwc_pkg::CODE_BITS_DEF;
    // No transaction for this long means the block hung. Worst legal quiet
    // spell: the long receiver hold-off (plus one full-dictionary lookup).
    localparam int unsigned STALL_LIMIT  = 4000;
    // Slowest single byte: a sweep of 240 rows and a pass through 16 cells
    localparam int unsigned SETTLE       = 300;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned RANDOM_ITEMS = 1700;
    localparam logic [8:0]  LAST         = 9'h100;   // final-byte flag in the directed list

    typedef enum int {
        MIX_NARROW,     // few distinct bytes: long matches, many hits
        MIX_UNIFORM,    // any byte: mostly misses
        MIX_SINGLE      // one-byte stream
    } mix_t;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_valid      = 1'b0;
    logic [7:0]        i_in_byte    = 8'h00;
    logic              i_final_byte = 1'b0;
    logic              i_ready      = 1'b0;
    logic              o_ready;
    logic              o_valid;
    logic [CODE_W-1:0] o_out_code;
    logic              o_end_of_stream;

    code_board   board;
    bit          sender_steady = 1'b0;   // sender offers back to back
    int unsigned random_sent   = 0;
    int unsigned results_seen  = 0;
    int unsigned hold_left     = 0;
    bit          held          = 1'b0;
    int unsigned stuck         = 0;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    lzw_byte_compressor uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_in_byte       (i_in_byte),
        .i_final_byte    (i_final_byte),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_code      (o_out_code),
        .o_end_of_stream (o_end_of_stream)
    );

    // Offer one byte, with random idle cycles in front, and hold it until
    // the input transaction completes. Entered and left at a rising edge.
    task automatic push_byte(input logic [7:0] b, input logic fin);
        while (!sender_steady && $urandom_range(99) < 16) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_in_byte    <= b;
        i_final_byte <= fin;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        board.note_byte(b, fin);
    endtask

    // One whole stream; the last byte carries the final flag
    task automatic push_stream(input mix_t mix, input int unsigned len);
        logic [7:0]  base;
        int unsigned span;
        logic [7:0]  b;
        base = 8'($urandom_range(255));
        span = $urandom_range(4, 1);
        for (int unsigned n = 0; n < len; n++) begin
            case (mix)
                MIX_NARROW: begin
                    b = base + 8'($urandom_range(span - 1));
                end
                default: begin
                    b = 8'($urandom_range(255));
                end
            endcase
            push_byte(b, n == len - 1);
            random_sent++;
        end
    endtask

    // Sender goes quiet until every expected code has come out
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (board.pending.size() != 0);
    endtask

    // Receiver: checks each output transaction, stalls about 16% of the
    // time, never stalls during one stretch of results, and once holds off
    // long enough for the block to back up and refuse input.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            board.check_code(o_out_code, o_end_of_stream);
            results_seen++;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (results_seen == 300 && !held) begin
            held      = 1'b1;
            hold_left = HOLD_CYCLES;
            i_ready   <= 1'b0;
        end else if (results_seen >= 1000 && results_seen < 1400) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(99) >= 16);
        end
    end

    // Watchdog: cycles in a row with no transaction on either side
    always @(posedge i_clk) begin
        if ((i_valid && o_ready === 1'b1) || (o_valid === 1'b1 && i_ready))
            stuck = 0;
        else
            stuck++;
        if (stuck >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", stuck);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        logic [8:0]  opening[$];
        int unsigned roll;
        bit          paused;

        board  = new();
        paused = 1'b0;
        // Directed: one-byte streams at both byte extremes, alternating
        // pair (hits, learned codes as prefixes), miss together with the
        // final byte, runs of one byte, the first of them flushing a learned code.
        opening = '{LAST | 9'h000, LAST | 9'h0FF,
                    9'h041, 9'h042, 9'h041, 9'h042, 9'h041, 9'h042, LAST | 9'h041,
                    9'h055, LAST | 9'h0AA,
                    9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, LAST | 9'h0FF,
                    9'h000, 9'h000, 9'h000, LAST | 9'h000};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (opening[k])
            push_byte(opening[k][7:0], opening[k][8]);
        wait_drained();

        // Random streams; one stretch with the sender never idling, and one
        // pause for the block to drain completely
        while (random_sent < RANDOM_ITEMS) begin
            roll          = $urandom_range(99);
            sender_steady = (random_sent >= 600 && random_sent < 900);
            if (!paused && random_sent >= 1100) begin
                wait_drained();
                paused = 1'b1;
            end
            if (roll < 70)
                push_stream(MIX_NARROW, $urandom_range(40, 2));
            else if (roll < 92)
                push_stream(MIX_UNIFORM, $urandom_range(20, 1));
            else
                push_stream(MIX_SINGLE, 1);
        end
        sender_steady = 1'b0;

        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        board.close_out();
        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
